>>> rtl/fbrm_pkg.sv
// ----------------------------------------------------------------------------
// fbrm_pkg
// Shared codes and types for the frame buffer rotation manager.
// ----------------------------------------------------------------------------
`default_nettype none

package fbrm_pkg;

	// word kinds
	localparam logic [1:0] KIND_EOF    = 2'd0;
	localparam logic [1:0] KIND_LOCK   = 2'd1;
	localparam logic [1:0] KIND_UNLOCK = 2'd2;
	localparam logic [1:0] KIND_STATUS = 2'd3;

	// owner codes
	localparam logic [1:0] OWNER_NONE    = 2'd0;
	localparam logic [1:0] OWNER_DECODER = 2'd1;
	localparam logic [1:0] OWNER_USB     = 2'd2;

	// buffer status codes
	localparam logic [2:0] ST_READY     = 3'd0;
	localparam logic [2:0] ST_CAPTURING = 3'd2;
	localparam logic [2:0] ST_UNUSED    = 3'd4;

	// configuration register indexes
	localparam logic [1:0] REG_SPLIT_COUNT   = 2'd0;
	localparam logic [1:0] REG_BUFFER_BASE   = 2'd1;
	localparam logic [1:0] REG_BUFFER_STRIDE = 2'd2;

	localparam logic [3:0]  SPLIT_RESET  = 4'd3;
	localparam logic [23:0] STRIDE_RESET = 24'd307200;

	typedef enum logic [1:0] {
		ALU_ADD = 2'd0,
		ALU_SUB = 2'd1,
		ALU_INC = 2'd2
	} alu_op_t;

	typedef struct packed {
		alu_op_t     op;
		logic [31:0] a;
		logic [31:0] b;
	} alu_req_t;

endpackage

`default_nettype wire

>>> rtl/fbrm_alu.sv
// ----------------------------------------------------------------------------
// fbrm_alu
// Shared 32-bit add/subtract/increment unit used by the sequencer for the
// sequence counter, the capture index search and the address shift-add.
// ----------------------------------------------------------------------------
`default_nettype none

module fbrm_alu
	import fbrm_pkg::*;
(
	input  wire alu_req_t    req,
	output logic [31:0]      y
);

	always_comb begin
		case (req.op)
			ALU_ADD: y = req.a + req.b;
			ALU_SUB: y = req.a - req.b;
			ALU_INC: y = req.a + 32'd1;
			default: y = req.a;
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/frame_buffer_rotation_manager.sv
// ----------------------------------------------------------------------------
// frame_buffer_rotation_manager
// Rotates camera frame buffers between capture and two consumers.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; busy then stays high
// until the word is finished, and done pulses for one cycle with the result,
// which the receiver must take in that cycle. All work runs on one shared
// 32-bit adder under a small sequencer: an evaluate step, then for an end
// of frame a capture index search (one increment or wrap subtract per cycle
// and a closing step that takes the index), then for every word one
// shift-add step per capture index bit to form the capture address.
// done rises the cycle after the last step.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_buffer_rotation_manager
	import fbrm_pkg::*;
#(
	parameter int MAX_BUFFERS = 8
) (
	input  wire         clk,
	input  wire         arst_n,

	input  wire         wr_en,
	input  wire  [1:0]  wr_index,
	input  wire  [31:0] wr_data,

	input  wire         start,
	output logic        busy,
	input  wire  [1:0]  kind,
	input  wire         consumer,
	input  wire         update_current,
	input  wire  [1:0]  new_owner,

	output logic        done,
	output logic        granted,
	output logic [2:0]  capture_index,
	output logic [31:0] capture_address,
	output logic [2:0]  ready_index,
	output logic        current_valid,
	output logic [2:0]  current_index,
	output logic [31:0] current_sequence,
	output logic [2:0]  current_status,
	output logic [1:0]  busy_flags,
	output logic [1:0]  owner
);

	localparam int IW = (MAX_BUFFERS > 8) ? $clog2(MAX_BUFFERS) : 3;
	localparam int SW = IW + 1;
	localparam int BW = $clog2(IW);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EVAL = 4'b0010,
		S_SKIP = 4'b0100,
		S_ADDR = 4'b1000
	} state_t;

	state_t         state_q;

	// configuration
	logic [3:0]     split_q;
	logic [31:0]    base_q;
	logic [23:0]    stride_q;

	// rotation state
	logic [31:0]    seq_cnt_q;
	logic [IW-1:0]  cap_q;
	logic [IW-1:0]  ready_q;
	logic           ready_present_q;
	logic [IW-1:0]  cur_q;
	logic           cur_present_q;
	logic [31:0]    cur_seq_q;
	logic [1:0]     busy_bits_q;
	logic [1:0]     owner_q;

	// word in flight
	logic [1:0]     kind_q;
	logic           who_q;
	logic           upd_q;
	logic [1:0]     nowner_q;
	logic           granted_q;

	// search and address sequencing
	logic [SW-1:0]  cand_q;
	logic           first_q;
	logic [31:0]    acc_q;
	logic [BW-1:0]  bit_q;

	// result registers
	logic           done_q;
	logic           res_granted_q;
	logic [2:0]     res_cap_idx_q;
	logic [31:0]    res_cap_addr_q;
	logic [2:0]     res_ready_idx_q;
	logic           res_cur_valid_q;
	logic [2:0]     res_cur_idx_q;
	logic [31:0]    res_cur_seq_q;
	logic [2:0]     res_cur_status_q;
	logic [1:0]     res_busy_q;
	logic [1:0]     res_owner_q;

	logic [SW-1:0]  split_ext;
	logic [SW-1:0]  s_eff;
	logic           cand_ge_s;
	logic           excluded;
	logic [2:0]     st_cur;
	logic [2:0]     st_ready;
	logic           cap_in_range;
	logic [1:0]     who_mask;
	logic [1:0]     busy_after_unlock;
	logic           lock_ok;
	logic           last_bit;
	alu_req_t       alu_req;
	logic [31:0]    alu_y;

	fbrm_alu u_alu (
		.req (alu_req),
		.y   (alu_y)
	);

	assign busy = (state_q != S_IDLE);

	// clamp split count to 3..MAX_BUFFERS
	always_comb begin
		split_ext = SW'(split_q);
		if (split_ext < SW'(3))
			s_eff = SW'(3);
		else if (split_ext > SW'(MAX_BUFFERS))
			s_eff = SW'(MAX_BUFFERS);
		else
			s_eff = split_ext;
	end

	assign cand_ge_s    = (cand_q >= s_eff);
	assign excluded     = (cur_present_q && (cand_q[IW-1:0] == cur_q)) ||
	                      (cand_q[IW-1:0] == ready_q);
	assign cap_in_range = ({1'b0, cap_q} < s_eff);

	// only the capture buffer is ever stamped capturing, once a frame has ended
	always_comb begin
		if ({1'b0, cur_q} >= s_eff)
			st_cur = ST_UNUSED;
		else if (ready_present_q && (cur_q == cap_q))
			st_cur = ST_CAPTURING;
		else
			st_cur = ST_READY;
		if ({1'b0, ready_q} >= s_eff)
			st_ready = ST_UNUSED;
		else if (ready_present_q && (ready_q == cap_q))
			st_ready = ST_CAPTURING;
		else
			st_ready = ST_READY;
	end

	assign who_mask          = who_q ? 2'b10 : 2'b01;
	assign busy_after_unlock = busy_bits_q & ~who_mask;
	assign lock_ok           = (busy_bits_q == 2'b00) && cur_present_q &&
	                           (st_cur == ST_READY) &&
	                           !(who_q && (owner_q == OWNER_DECODER));
	assign last_bit          = (bit_q == BW'(IW - 1));

	always_comb begin
		alu_req.op = ALU_ADD;
		alu_req.a  = 32'd0;
		alu_req.b  = 32'd0;
		case (state_q)
			S_EVAL: begin
				alu_req.op = ALU_INC;
				alu_req.a  = seq_cnt_q;
			end
			S_SKIP: begin
				alu_req.a = 32'(cand_q);
				if (cand_ge_s) begin
					alu_req.op = ALU_SUB;
					alu_req.b  = 32'(s_eff);
				end else begin
					alu_req.op = ALU_INC;
				end
			end
			S_ADDR: begin
				alu_req.op = ALU_ADD;
				alu_req.a  = acc_q;
				alu_req.b  = cap_q[bit_q] ? (32'(stride_q) << bit_q) : 32'd0;
			end
			default: begin
				alu_req.op = ALU_ADD;
			end
		endcase
	end

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_q  <= SPLIT_RESET;
			base_q   <= 32'd0;
			stride_q <= STRIDE_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_SPLIT_COUNT:   split_q  <= wr_data[3:0];
				REG_BUFFER_BASE:   base_q   <= wr_data;
				REG_BUFFER_STRIDE: stride_q <= wr_data[23:0];
				default: ;
			endcase
		end
	end

	// word capture
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			kind_q   <= kind;
			who_q    <= consumer;
			upd_q    <= update_current;
			nowner_q <= new_owner;
		end
	end

	// sequencer and rotation state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			seq_cnt_q       <= 32'd0;
			cap_q           <= '0;
			ready_q         <= '0;
			ready_present_q <= 1'b0;
			cur_q           <= '0;
			cur_present_q   <= 1'b0;
			cur_seq_q       <= 32'd0;
			busy_bits_q     <= 2'b00;
			owner_q         <= OWNER_NONE;
			granted_q       <= 1'b0;
			cand_q          <= '0;
			first_q         <= 1'b0;
			acc_q           <= 32'd0;
			bit_q           <= '0;
			done_q          <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					granted_q <= 1'b0;
					acc_q     <= base_q;
					bit_q     <= '0;
					state_q   <= S_ADDR;
					case (kind_q)
						KIND_EOF: begin
							seq_cnt_q       <= alu_y;
							ready_q         <= cap_q;
							ready_present_q <= 1'b1;
							if ((busy_bits_q == 2'b00) && cap_in_range) begin
								cur_q         <= cap_q;
								cur_present_q <= 1'b1;
								cur_seq_q     <= alu_y;
							end
							cand_q  <= SW'(cap_q);
							first_q <= 1'b1;
							state_q <= S_SKIP;
						end
						KIND_LOCK: begin
							if (lock_ok) begin
								granted_q   <= 1'b1;
								busy_bits_q <= busy_bits_q | who_mask;
							end
						end
						KIND_UNLOCK: begin
							if (ready_present_q) begin
								busy_bits_q <= busy_after_unlock;
								owner_q     <= nowner_q;
								// ready buffer carries the latest sequence number
								if (upd_q && (st_ready == ST_READY) &&
								    (busy_after_unlock == 2'b00)) begin
									cur_q         <= ready_q;
									cur_present_q <= 1'b1;
									cur_seq_q     <= seq_cnt_q;
								end
							end
						end
						default: ;
					endcase
				end
				S_SKIP: begin
					// wrap first, then step past current and ready
					if (cand_ge_s) begin
						cand_q <= alu_y[SW-1:0];
					end else if (first_q || excluded) begin
						cand_q  <= alu_y[SW-1:0];
						first_q <= 1'b0;
					end else begin
						cap_q   <= cand_q[IW-1:0];
						acc_q   <= base_q;
						bit_q   <= '0;
						state_q <= S_ADDR;
					end
				end
				S_ADDR: begin
					acc_q <= alu_y;
					bit_q <= bit_q + BW'(1);
					if (last_bit) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result words
	always_ff @(posedge clk) begin
		if ((state_q == S_ADDR) && last_bit) begin
			res_granted_q    <= granted_q;
			res_cap_idx_q    <= cap_q[2:0];
			res_cap_addr_q   <= alu_y;
			res_ready_idx_q  <= ready_q[2:0];
			res_cur_valid_q  <= cur_present_q;
			res_cur_idx_q    <= cur_present_q ? cur_q[2:0] : 3'd0;
			res_cur_seq_q    <= cur_present_q ? cur_seq_q : 32'd0;
			res_cur_status_q <= cur_present_q ? st_cur : ST_UNUSED;
			res_busy_q       <= busy_bits_q;
			res_owner_q      <= owner_q;
		end
	end

	assign done             = done_q;
	assign granted          = res_granted_q;
	assign capture_index    = res_cap_idx_q;
	assign capture_address  = res_cap_addr_q;
	assign ready_index      = res_ready_idx_q;
	assign current_valid    = res_cur_valid_q;
	assign current_index    = res_cur_idx_q;
	assign current_sequence = res_cur_seq_q;
	assign current_status   = res_cur_status_q;
	assign busy_flags       = res_busy_q;
	assign owner            = res_owner_q;

	// a result only follows the last address step
	a_done_after_addr: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == S_ADDR))
		else $error("done without a finished address step");

	// locks are exclusive
	a_busy_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(busy_bits_q))
		else $error("both consumers hold a lock");

	// capture never lands on the current buffer
	a_cap_not_current: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_present_q && (state_q == S_IDLE)) |-> (cap_q != cur_q))
		else $error("capture index equals current index");

	// a taken word always leads to evaluation
	a_start_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == S_EVAL))
		else $error("accepted word not evaluated");

endmodule

`default_nettype wire
